@@ rtl/core/sphf_pkg.sv @@
// Package for the SPH pair force accumulator: widths, register codes,
// sequencer states and saturation helpers. No dependencies.
`default_nettype none
package sphf_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COEF_FRAC      = 40;
    localparam int WORK_W         = 48;
    localparam int CFG_W          = 48;
    localparam int CFG_IDX_W      = 3;

    typedef logic signed [WORK_W-1:0] work_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS = 3'd0,
        REG_MASS   = 3'd1,
        REG_VISCM  = 3'd2,
        REG_SPIKY  = 3'd3,
        REG_VLAP   = 3'd4,
        REG_GRAV   = 3'd5
    } cfg_reg_t;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
        logic    coef;    // product shift is COEF_FRAC instead of FRAC_BITS
    } alu_cmd_t;

    typedef enum logic [4:0] {
        S_IDLE, S_RANGE, S_SQRT, S_UX, S_UY, S_R2, S_R3, S_PC, S_PR, S_PRPC,
        S_K, S_VC, S_VX, S_VXC, S_FX, S_VY, S_VYC, S_FY, S_PX, S_PY,
        S_ACC, S_GRAV, S_OUT
    } seq_state_t;

    localparam work_t WORK_MAX = {1'b0, {(WORK_W-1){1'b1}}};
    localparam work_t WORK_MIN = {1'b1, {(WORK_W-1){1'b0}}};

    // Saturate a 49-bit sum to the working width.
    function automatic work_t sat49(input logic signed [WORK_W:0] v);
        if (v > $signed({1'b0, WORK_MAX})) return WORK_MAX;
        if (v < $signed({1'b1, WORK_MIN})) return WORK_MIN;
        return v[WORK_W-1:0];
    endfunction

    // Turn a magnitude and sign into a saturated working value.
    function automatic work_t sat_mag(input logic [63:0] m, input logic neg);
        if (m > 64'(WORK_MAX)) return neg ? WORK_MIN : WORK_MAX;
        return neg ? work_t'(-m[WORK_W-1:0]) : work_t'(m[WORK_W-1:0]);
    endfunction

    function automatic logic [WORK_W-1:0] mag_of(input work_t v);
        return v[WORK_W-1] ? -v : v;
    endfunction
endpackage
`default_nettype wire

@@ rtl/core/sphf_stream_if.sv @@
// Valid/ready stream interface carrying one payload struct.
// Depends on nothing but the payload type handed in.
`default_nettype none
interface sphf_stream_if #(parameter type payload_t = logic) (input wire logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/sphf_alu.sv @@
// Shared multi-cycle arithmetic unit: 48x48 multiply with shift by
// partial products, restoring fixed point divide, integer square root.
// Depends on sphf_pkg.
`default_nettype none
module sphf_alu #(
    parameter int FRAC_BITS = sphf_pkg::FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sphf_pkg::alu_cmd_t cmd,
    input  wire sphf_pkg::work_t   a,
    input  wire sphf_pkg::work_t   b,
    input  wire logic [63:0]       radicand,
    output logic                   busy,
    output logic                   done,
    output sphf_pkg::work_t        result
);
    import sphf_pkg::*;

    localparam int CNT_W = 7;
    localparam int QLIM_W = WORK_W - FRAC_BITS - 1;
    localparam int SQRT_STEPS = 32;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    alu_op_t            op_reg, op_next;
    logic               coef_reg, coef_next;
    logic               neg_reg, neg_next;
    logic [WORK_W-1:0]  ma_reg, ma_next;
    logic [WORK_W-1:0]  mb_reg, mb_next;
    logic [95:0]        acc_reg, acc_next;
    logic [63:0]        rem_reg, rem_next;
    logic [63:0]        quo_reg, quo_next;
    logic               ovf_reg, ovf_next;
    work_t              result_reg, result_next;

    logic [63:0]        rem_sh, sq_trial;
    logic [95:0]        prod_sh;

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        op_next = op_reg; coef_next = coef_reg; neg_next = neg_reg;
        ma_next = ma_reg; mb_next = mb_reg; acc_next = acc_reg;
        rem_next = rem_reg; quo_next = quo_reg; ovf_next = ovf_reg;
        result_next = result_reg;
        rem_sh = '0; sq_trial = '0; prod_sh = '0;
        if (!busy_reg && cmd.start)
        begin
            busy_next = 1'b1; op_next = cmd.op; coef_next = cmd.coef;
            neg_next = a[WORK_W-1] ^ b[WORK_W-1];
            ma_next = mag_of(a); mb_next = mag_of(b);
            acc_next = '0; cnt_next = '0; quo_next = '0; ovf_next = 1'b0;
            rem_next = '0;
            if (cmd.op == OP_DIV)
            begin
                neg_next = a[WORK_W-1];
                mb_next = b;               // divisor is positive
            end
            else if (cmd.op == OP_SQRT)
            begin
                rem_next = radicand;       // radicand, unsigned
                acc_next = '0;
            end
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    // Four partial products: a halves by b halves.
                    unique case (cnt_reg[1:0])
                        2'd0: acc_next = acc_reg + 96'(48'(ma_reg[23:0]) * 48'(mb_reg[23:0]));
                        2'd1: acc_next = acc_reg + (96'(48'(ma_reg[23:0]) * 48'(mb_reg[47:24])) << 24);
                        2'd2: acc_next = acc_reg + (96'(48'(ma_reg[47:24]) * 48'(mb_reg[23:0])) << 24);
                        default: acc_next = acc_reg + (96'(48'(ma_reg[47:24]) * 48'(mb_reg[47:24])) << 48);
                    endcase
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(4))
                    begin
                        prod_sh = coef_reg ? (acc_reg >> COEF_FRAC) : (acc_reg >> FRAC_BITS);
                        result_next = (prod_sh[95:64] != '0) ? sat_mag('1, neg_reg)
                                                             : sat_mag(prod_sh[63:0], neg_reg);
                        acc_next = acc_reg; busy_next = 1'b0; done_next = 1'b1;
                    end
                end
                OP_DIV:
                begin
                    // Restoring divide of |a| << FRAC_BITS, one quotient bit a cycle.
                    rem_sh = {rem_reg[62:0], (cnt_reg < CNT_W'(WORK_W)) ?
                              ma_reg[WORK_W-1-cnt_reg[5:0]] : 1'b0};
                    if (cnt_reg < CNT_W'(WORK_W + FRAC_BITS))
                    begin
                        if (rem_sh >= 64'(mb_reg))
                        begin
                            rem_next = rem_sh - 64'(mb_reg);
                            quo_next = {quo_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            rem_next = rem_sh;
                            quo_next = {quo_reg[62:0], 1'b0};
                        end
                        // Integer quotient above the limit saturates.
                        if (cnt_reg == CNT_W'(WORK_W - 1) &&
                            quo_next[WORK_W-1:0] > {{(FRAC_BITS+1){1'b0}}, {QLIM_W{1'b1}}})
                            ovf_next = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        result_next = ovf_reg ? sat_mag('1, neg_reg) : sat_mag(quo_reg, neg_reg);
                        busy_next = 1'b0; done_next = 1'b1;
                    end
                end
                OP_SQRT:
                begin
                    // Digit-by-digit root of a 64-bit radicand, one bit a cycle.
                    if (cnt_reg < CNT_W'(SQRT_STEPS))
                    begin
                        sq_trial = quo_reg + (64'(1) << (2*(SQRT_STEPS - 1 - cnt_reg[4:0])));
                        if (rem_reg >= sq_trial)
                        begin
                            rem_next = rem_reg - sq_trial;
                            quo_next = (quo_reg >> 1) +
                                       (64'(1) << (2*(SQRT_STEPS - 1 - cnt_reg[4:0])));
                        end
                        else
                            quo_next = quo_reg >> 1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        result_next = work_t'(quo_reg[WORK_W-1:0]);
                        busy_next = 1'b0; done_next = 1'b1;
                    end
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next; coef_reg <= coef_next; neg_reg <= neg_next;
        ma_reg <= ma_next; mb_reg <= mb_next; acc_reg <= acc_next;
        rem_reg <= rem_next; quo_reg <= quo_next; ovf_reg <= ovf_next;
        result_reg <= result_next;
    end

    // A result is flagged only as the unit goes idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("alu done while busy");
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("alu done without work");
    assert property (@(posedge clk) disable iff (!rst_n) busy && !done |=> busy || done)
        else $error("alu dropped an operation");
endmodule
`default_nettype wire

@@ rtl/core/sph_pair_force_accumulate.sv @@
// SPH pair force accumulator.
// Channels: pair_in (sink) carries one neighbour pair per transfer; force_out
// (source) carries one force result after each pair marked last. A plain write
// port (cfg_we, cfg_index, cfg_data) sets the six coefficients; write only when idle.
// Each pair runs through a sequencer that drives one shared arithmetic unit:
// a square root, three or five fixed point divides and twelve multiplies.
// A skipped or out-of-range pair goes from its range check to the gravity
// state; a last pair then adds a gravity divide, unless its own density is
// zero, and the output state.
// pair_in.ready is high only while the sequencer is idle.
// The force result is held in an output register; a stalled receiver keeps it
// there and the block takes no new pair until it has been transferred.
// Reset clears the sums, the fault flag and the coefficients to their defaults.
// Depends on sphf_pkg, sphf_stream_if and sphf_alu.
`default_nettype none
module sph_pair_force_accumulate #(
    parameter int DATA_WIDTH = sphf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = sphf_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    sphf_stream_if.sink                      pair_in,
    sphf_stream_if.source                    force_out,
    input  wire logic                        cfg_we,
    input  wire logic [sphf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sphf_pkg::CFG_W-1:0]  cfg_data
);
    import sphf_pkg::*;

    localparam int DW = DATA_WIDTH;

    // Configuration registers.
    logic [30:0]          radius_reg, mass_reg, viscm_reg;
    logic signed [47:0]   spiky_reg, vlap_reg;
    logic signed [DW-1:0] grav_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 31'd1048576; mass_reg <= 31'd163840; viscm_reg <= 31'd32768000;
            spiky_reg <= -48'sd3337674; vlap_reg <= 48'sd13350696;
            grav_reg <= DW'(-32'sd1638400);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_data[30:0];
                REG_MASS:   mass_reg   <= cfg_data[30:0];
                REG_VISCM:  viscm_reg  <= cfg_data[30:0];
                REG_SPIKY:  spiky_reg  <= cfg_data[47:0];
                REG_VLAP:   vlap_reg   <= cfg_data[47:0];
                REG_GRAV:   grav_reg   <= cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // Captured pair.
    work_t dx_reg, dy_reg, vx_reg, vy_reg, psum_reg;
    logic [DW-2:0] rho_reg, own_reg;
    logic self_reg, last_reg;

    // Intermediate registers.
    work_t d_reg, ux_reg, uy_reg, r_reg, t_reg, k_reg, vc_reg, fx_reg, fy_reg;
    work_t px_reg, py_reg, gy_reg;
    work_t sum_x_reg, sum_y_reg;
    logic  fault_reg;
    seq_state_t state_reg, state_next;

    logic [WORK_W-1:0] mx, my;
    logic [63:0] d2, h2;
    logic in_range;

    alu_cmd_t cmd;
    work_t alu_a, alu_b, alu_res;
    logic alu_busy, alu_done;

    sphf_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .clk, .rst_n, .cmd, .a(alu_a), .b(alu_b), .radicand(d2),
        .busy(alu_busy), .done(alu_done), .result(alu_res)
    );

    // Exact range test on captured position.
    assign mx = mag_of(dx_reg);
    assign my = mag_of(dy_reg);
    assign d2 = 64'(mx[DW-1:0]) * 64'(mx[DW-1:0]) + 64'(my[DW-1:0]) * 64'(my[DW-1:0]);
    assign h2 = 64'(radius_reg) * 64'(radius_reg);
    assign in_range = (mx < 48'(radius_reg)) && (my < 48'(radius_reg)) && (d2 < h2);

    logic out_valid_reg;
    logic [DW-1:0] out_fx_reg, out_fy_reg;
    logic out_fault_reg;

    assign pair_in.ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign force_out.valid = out_valid_reg;
    assign force_out.data.force_x = out_fx_reg;
    assign force_out.data.force_y = out_fy_reg;
    assign force_out.data.divide_fault = out_fault_reg;

    // Sequencer: each operation state issues one unit operation and waits for it.
    always_comb
    begin
        state_next = state_reg;
        cmd = '{start: 1'b0, op: OP_MUL, coef: 1'b0};
        alu_a = '0; alu_b = '0;
        unique case (state_reg)
            S_IDLE:
                if (pair_in.valid && pair_in.ready) state_next = S_RANGE;
            S_RANGE:
                if (self_reg || !in_range || rho_reg == '0) state_next = S_GRAV;
                else state_next = S_SQRT;
            S_SQRT: cmd.op = OP_SQRT;
            S_UX:   begin cmd.op = OP_DIV; alu_a = dx_reg; alu_b = d_reg; end
            S_UY:   begin cmd.op = OP_DIV; alu_a = dy_reg; alu_b = d_reg; end
            S_R2:   begin alu_a = r_reg; alu_b = r_reg; end
            S_R3:   begin alu_a = t_reg; alu_b = r_reg; end
            S_PC:   begin cmd.coef = 1'b1; alu_a = spiky_reg; alu_b = t_reg; end
            S_PR:   begin alu_a = work_t'(mass_reg); alu_b = psum_reg; end
            S_PRPC: begin alu_a = k_reg; alu_b = t_reg; end
            S_K:    begin cmd.op = OP_DIV; alu_a = t_reg; alu_b = work_t'({rho_reg, 1'b0}); end
            S_VC:   begin cmd.coef = 1'b1; alu_a = vlap_reg; alu_b = r_reg; end
            S_VX:   begin alu_a = work_t'(viscm_reg); alu_b = vx_reg; end
            S_VXC:  begin alu_a = t_reg; alu_b = vc_reg; end
            S_FX:   begin cmd.op = OP_DIV; alu_a = t_reg; alu_b = work_t'(rho_reg); end
            S_VY:   begin alu_a = work_t'(viscm_reg); alu_b = vy_reg; end
            S_VYC:  begin alu_a = t_reg; alu_b = vc_reg; end
            S_FY:   begin cmd.op = OP_DIV; alu_a = t_reg; alu_b = work_t'(rho_reg); end
            S_PX:   begin alu_a = ux_reg; alu_b = k_reg; end
            S_PY:   begin alu_a = uy_reg; alu_b = k_reg; end
            S_ACC:  state_next = S_GRAV;
            S_GRAV:
                if (!last_reg) state_next = S_IDLE;
                else if (own_reg == '0) state_next = S_OUT;
                else
                begin
                    cmd.op = OP_DIV; alu_a = work_t'(grav_reg); alu_b = work_t'(own_reg);
                end
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        // Operation states: start the unit, then advance on its done.
        if (state_reg != S_IDLE && state_reg != S_RANGE && state_reg != S_ACC &&
            state_reg != S_OUT && !(state_reg == S_GRAV && (!last_reg || own_reg == '0)))
        begin
            cmd.start = !alu_busy && !alu_done;
            if (alu_done)
            begin
                unique case (state_reg)
                    S_SQRT: state_next = (alu_res == '0) ? S_R2 : S_UX;
                    S_UX:   state_next = S_UY;
                    S_UY:   state_next = S_R2;
                    S_R2:   state_next = S_R3;
                    S_R3:   state_next = S_PC;
                    S_PC:   state_next = S_PR;
                    S_PR:   state_next = S_PRPC;
                    S_PRPC: state_next = S_K;
                    S_K:    state_next = S_VC;
                    S_VC:   state_next = S_VX;
                    S_VX:   state_next = S_VXC;
                    S_VXC:  state_next = S_FX;
                    S_FX:   state_next = S_VY;
                    S_VY:   state_next = S_VYC;
                    S_VYC:  state_next = S_FY;
                    S_FY:   state_next = S_PX;
                    S_PX:   state_next = S_PY;
                    S_PY:   state_next = S_ACC;
                    default: state_next = S_OUT;   // gravity divide
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else        state_reg <= state_next;
    end

    // Datapath registers follow unit results.
    always_ff @(posedge clk)
    begin
        if (pair_in.valid && pair_in.ready)
        begin
            dx_reg <= WORK_W'(pair_in.data.rel_pos_x);
            dy_reg <= WORK_W'(pair_in.data.rel_pos_y);
            vx_reg <= WORK_W'(pair_in.data.rel_vel_x);
            vy_reg <= WORK_W'(pair_in.data.rel_vel_y);
            psum_reg <= WORK_W'(pair_in.data.own_pressure) +
                        WORK_W'(pair_in.data.neighbour_pressure);
            rho_reg <= pair_in.data.neighbour_density;
            own_reg <= pair_in.data.own_density;
            self_reg <= pair_in.data.self_pair;
            last_reg <= pair_in.data.last_pair;
            ux_reg <= '0; uy_reg <= '0; gy_reg <= '0;
        end
        if (alu_done)
        begin
            unique case (state_reg)
                S_SQRT: begin d_reg <= alu_res; r_reg <= work_t'(radius_reg) - alu_res; end
                S_UX:   ux_reg <= alu_res;
                S_UY:   uy_reg <= alu_res;
                S_PR:   k_reg <= alu_res;
                S_K:    k_reg <= alu_res;
                S_VC:   vc_reg <= alu_res;
                S_FX:   fx_reg <= alu_res;
                S_FY:   fy_reg <= alu_res;
                S_PX:   px_reg <= alu_res;
                S_PY:   py_reg <= alu_res;
                S_GRAV: gy_reg <= alu_res;
                default: t_reg <= alu_res;
            endcase
        end
    end

    // Saturate a working value to the output width.
    function automatic logic [DW-1:0] sat_dw(input work_t v);
        if (v > work_t'({1'b0, {(DW-1){1'b1}}})) return {1'b0, {(DW-1){1'b1}}};
        if (v < -work_t'({1'b0, {(DW-1){1'b1}}}) - work_t'(1)) return {1'b1, {(DW-1){1'b0}}};
        return v[DW-1:0];
    endfunction

    // Running sums, fault flag and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg <= '0; sum_y_reg <= '0; fault_reg <= 1'b0; out_valid_reg <= 1'b0;
            out_fault_reg <= 1'b0; out_fx_reg <= '0; out_fy_reg <= '0;
        end
        else
        begin
            if (force_out.valid && force_out.ready) out_valid_reg <= 1'b0;
            if (state_reg == S_RANGE && !self_reg && in_range && rho_reg == '0)
                fault_reg <= 1'b1;
            if (state_reg == S_ACC)
            begin
                sum_x_reg <= sat49(49'(sat49(49'(sum_x_reg) - 49'(px_reg))) + 49'(fx_reg));
                sum_y_reg <= sat49(49'(sat49(49'(sum_y_reg) - 49'(py_reg))) + 49'(fy_reg));
            end
            if (state_reg == S_OUT)
            begin
                out_valid_reg <= 1'b1;
                out_fault_reg <= fault_reg || (own_reg == '0);
                out_fx_reg <= sat_dw(sum_x_reg);
                out_fy_reg <= sat_dw(sat49(49'(sum_y_reg) + 49'(gy_reg)));
                sum_x_reg <= '0; sum_y_reg <= '0; fault_reg <= 1'b0;
            end
        end
    end

    // A result is raised only from the output state and never while one waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside output state");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !force_out.ready |=> out_valid_reg)
        else $error("waiting result lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        pair_in.ready |-> state_reg == S_IDLE && !alu_busy)
        else $error("ready while working");
endmodule
`default_nettype wire

@@ tb/tb_sphf_types_pkg.sv @@
// Payload types of the two stream channels of the SPH pair force accumulator.
// Depends on nothing; used by the checker and the testbench top.
`timescale 1ns / 1ps
package tb_sphf_types_pkg;
    typedef struct packed {
        logic signed [31:0] rel_pos_x;
        logic signed [31:0] rel_pos_y;
        logic signed [31:0] rel_vel_x;
        logic signed [31:0] rel_vel_y;
        logic signed [31:0] own_pressure;
        logic signed [31:0] neighbour_pressure;
        logic [30:0]        neighbour_density;
        logic [30:0]        own_density;
        logic               self_pair;
        logic               last_pair;
    } pair_t;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic               divide_fault;
    } force_t;
endpackage

@@ tb/sphf_force_checker.sv @@
// Watches the pair, force and register write channels, predicts each force
// result and compares it. Depends on sphf_pkg, tb_sphf_types_pkg, sphf_stream_if.
`timescale 1ns / 1ps
module sphf_force_checker
    import sphf_pkg::*;
    import tb_sphf_types_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    sphf_stream_if                  pair_ch,
    sphf_stream_if                  force_ch,
    input  wire logic               cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    output int                      mismatches,
    output int                      pending
);
    localparam longint SAT48 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SAT32 = 64'sh0000_0000_7FFF_FFFF;
    localparam int     FRAC  = 16;

    // Coefficient copies and running sums of the predictor.
    logic [63:0] radius, mass, visc_mass;
    longint      spiky, vlap, grav_mass;
    longint      sum_x, sum_y;
    bit          fault;
    force_t      expected_forces[$];

    function automatic logic [63:0] magn(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint clamp(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim - 1) return -lim - 1;
        return v;
    endfunction

    function automatic longint from_mag(logic [63:0] m, bit neg);
        if (m > 64'(SAT48)) return neg ? -SAT48 - 1 : SAT48;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // Exact product, shifted, truncated toward zero, saturated.
    function automatic longint fx_mul(longint a, longint b, int sh);
        logic [127:0] p;
        logic [63:0]  m;
        p = {64'd0, magn(a)} * {64'd0, magn(b)};
        p = p >> sh;
        m = (p[127:64] != 0) ? '1 : p[63:0];
        return from_mag(m, (a < 0) != (b < 0));
    endfunction

    // Exact quotient (t << FRAC) / d, truncated toward zero, saturated.
    function automatic longint fx_div(longint t, logic [63:0] d);
        logic [63:0]  m;
        logic [127:0] q;
        m = magn(t);
        if (m / d > (64'(SAT48) >> FRAC)) return from_mag('1, t < 0);
        q = ({64'd0, m} << FRAC) / {64'd0, d};
        return from_mag(q[63:0], t < 0);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res, trial;
        res = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = res | (64'd1 << b);
            if (trial * trial <= v) res = trial;
        end
        return res;
    endfunction

    // Adds the pressure and viscosity terms of one neighbour pair.
    function automatic void accumulate_pair(pair_t p);
        longint      dx, dy, ux, uy, r, r3, pc, pr, k, vc, fvx, fvy;
        logic [63:0] mx, my, d2, d, rho;
        dx = p.rel_pos_x;
        dy = p.rel_pos_y;
        mx = magn(dx);
        my = magn(dy);
        ux = 0;
        uy = 0;
        if (mx >= radius || my >= radius) return;
        d2 = mx * mx + my * my;
        if (d2 >= radius * radius) return;
        rho = 64'(p.neighbour_density);
        if (rho == 0) begin
            fault = 1'b1;
            return;
        end
        d = int_sqrt(d2);
        if (d != 0) begin
            ux = fx_div(dx, d);
            uy = fx_div(dy, d);
        end
        r   = longint'(radius - d);
        r3  = fx_mul(fx_mul(r, r, FRAC), r, FRAC);
        pc  = fx_mul(spiky, r3, COEF_FRAC);
        pr  = fx_mul(longint'(mass),
                     clamp(longint'(p.own_pressure) + longint'(p.neighbour_pressure), SAT48),
                     FRAC);
        k   = fx_div(fx_mul(pr, pc, FRAC), 2 * rho);
        vc  = fx_mul(vlap, r, COEF_FRAC);
        fvx = fx_div(fx_mul(fx_mul(longint'(visc_mass), longint'(p.rel_vel_x), FRAC), vc, FRAC),
                     rho);
        fvy = fx_div(fx_mul(fx_mul(longint'(visc_mass), longint'(p.rel_vel_y), FRAC), vc, FRAC),
                     rho);
        sum_x = clamp(sum_x - fx_mul(ux, k, FRAC), SAT48);
        sum_y = clamp(sum_y - fx_mul(uy, k, FRAC), SAT48);
        sum_x = clamp(sum_x + fvx, SAT48);
        sum_y = clamp(sum_y + fvy, SAT48);
    endfunction

    // Handles one accepted pair; a last pair closes the particle.
    function automatic void take_pair(pair_t p);
        longint gy;
        force_t f;
        gy = 0;
        if (!p.self_pair) accumulate_pair(p);
        if (!p.last_pair) return;
        if (p.own_density == 0) fault = 1'b1;
        else gy = fx_div(grav_mass, 64'(p.own_density));
        f.force_x      = 32'(clamp(sum_x, SAT32));
        f.force_y      = 32'(clamp(clamp(sum_y + gy, SAT48), SAT32));
        f.divide_fault = fault;
        expected_forces.push_back(f);
        sum_x = 0;
        sum_y = 0;
        fault = 1'b0;
    endfunction

    assign pending = expected_forces.size();

    always @(posedge clk or negedge rst_n) begin
        force_t want, got;
        if (!rst_n) begin
            radius     <= 64'd1048576;
            mass       <= 64'd163840;
            visc_mass  <= 64'd32768000;
            spiky      <= -64'sd3337674;
            vlap       <= 64'sd13350696;
            grav_mass  <= -64'sd1638400;
            sum_x      = 0;
            sum_y      = 0;
            fault      = 1'b0;
            mismatches <= 0;
            expected_forces.delete();
        end else begin
            // Results are checked before this edge's pair, which is later in order.
            if (force_ch.valid && force_ch.ready) begin
                got = force_ch.data;
                if (expected_forces.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: force transfer with none expected: %h", $time, got);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_forces.pop_front();
                    if (got.force_x !== want.force_x || got.force_y !== want.force_y
                        || got.divide_fault !== want.divide_fault) begin
                        if (mismatches < 10)
                            $display("%0t: force mismatch: expected x=%0d y=%0d f=%0b, got x=%0d y=%0d f=%0b",
                                     $time, want.force_x, want.force_y, want.divide_fault,
                                     got.force_x, got.force_y, got.divide_fault);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (pair_ch.valid && pair_ch.ready) take_pair(pair_ch.data);
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_RADIUS: radius    <= 64'(cfg_data[30:0]);
                    REG_MASS:   mass      <= 64'(cfg_data[30:0]);
                    REG_VISCM:  visc_mass <= 64'(cfg_data[30:0]);
                    REG_SPIKY:  spiky     <= longint'($signed(cfg_data[47:0]));
                    REG_VLAP:   vlap      <= longint'($signed(cfg_data[47:0]));
                    REG_GRAV:   grav_mass <= longint'($signed(cfg_data[31:0]));
                    default: ;
                endcase
            end
        end
    end
endmodule

@@ tb/tb_top.sv @@
// Testbench top: drives neighbour pairs and register writes into the SPH pair
// force accumulator and gives the verdict. Depends on sphf_pkg, the payload types and the checker.
`timescale 1ns / 1ps
module tb_top;
    import sphf_pkg::*;
    import tb_sphf_types_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 800;
    localparam int LONG_HOLD   = 3000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   mismatches;
    int                   pending;
    int                   cycles;
    int                   burst_left;
    bit                   long_hold_req;
    logic [63:0]          cur_radius;

    sphf_stream_if #(.payload_t(pair_t))  pair_ch (clk);
    sphf_stream_if #(.payload_t(force_t)) force_ch (clk);

    sph_pair_force_accumulate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pair_in   (pair_ch),
        .force_out (force_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sphf_force_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_ch    (pair_ch),
        .force_ch   (force_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Force receiver: always, half or one-in-eight ready, picked at random, plus one long hold-off.
    initial
    begin
        int mode_cnt;
        int mode;
        force_ch.ready <= 1'b0;
        mode_cnt = 0;
        mode = 0;
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                force_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end else begin
                mode_cnt++;
                if (mode_cnt % 256 == 0) mode = $urandom_range(0, 2);
                case (mode)
                    0: force_ch.ready <= 1'b1;
                    1: force_ch.ready <= ($urandom_range(0, 1) == 1);
                    default: force_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Register write; called just after a rising edge, leaves the enable high.
    task automatic cfg_write(cfg_reg_t idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_RADIUS) cur_radius = 64'(val[30:0]);
        @(posedge clk);
    endtask

    task automatic write_all(logic [30:0] h, logic [30:0] m, logic [30:0] vm,
                             logic [47:0] sp, logic [47:0] vl, logic [31:0] g);
        cfg_write(REG_RADIUS, CFG_W'(h));
        cfg_write(REG_MASS, CFG_W'(m));
        cfg_write(REG_VISCM, CFG_W'(vm));
        cfg_write(REG_SPIKY, CFG_W'(sp));
        cfg_write(REG_VLAP, CFG_W'(vl));
        cfg_write(REG_GRAV, CFG_W'(g));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one pair and waits for its transfer; gaps come between bursts.
    task automatic send_pair(pair_t p);
        pair_ch.valid <= 1'b1;
        pair_ch.data  <= p;
        do @(posedge clk); while (!pair_ch.ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 10);
            pair_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Lets the checker see the last transfer before waiting on its pending count.
    task automatic drain();
        pair_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [30:0] pick_density();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return 31'($urandom);
            default: return 31'($urandom_range(1 << 14, 1 << 20));
        endcase
    endfunction

    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $signed($urandom) >>> $urandom_range(8, 20);
    endfunction

    function automatic logic signed [31:0] pick_offset();
        logic [31:0] m;
        logic [63:0] h;
        h = (cur_radius == 0) ? 64'd65536 : cur_radius;
        m = $urandom_range(0, 32'(h - 1)) >> $urandom_range(0, 1);
        if ($urandom_range(0, 7) == 0) m = 32'(h) + $urandom_range(0, 1000);
        return $urandom_range(0, 1) ? -$signed(m) : $signed(m);
    endfunction

    function automatic pair_t random_pair(bit last);
        pair_t p;
        p.rel_pos_x          = pick_offset();
        p.rel_pos_y          = pick_offset();
        p.rel_vel_x          = pick_value();
        p.rel_vel_y          = pick_value();
        p.own_pressure       = pick_value();
        p.neighbour_pressure = pick_value();
        p.neighbour_density  = pick_density();
        p.own_density        = pick_density();
        p.self_pair          = ($urandom_range(0, 11) == 0);
        p.last_pair          = last;
        return p;
    endfunction

    function automatic pair_t noise_pair();
        pair_t p;
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom};
        return p;
    endfunction

    function automatic pair_t mk(int dx, int dy, int vx, int vy, int po, int pn,
                                 logic [30:0] rn, logic [30:0] ro, bit sp, bit lp);
        pair_t p;
        p = '{dx, dy, vx, vy, po, pn, rn, ro, sp, lp};
        return p;
    endfunction

    // Well-formed particles with random content, some noise pairs between them.
    task automatic random_phase(int n_items);
        int sent;
        int n;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                send_pair(noise_pair());
                sent++;
            end else begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) send_pair(random_pair(i == n - 1));
                sent += n;
            end
        end
        send_pair(mk(0, 0, 0, 0, 0, 0, 31'd65536, 31'd65536, 1'b1, 1'b1));
    endtask

    localparam int ONE  = 65536;
    localparam int PMAX = 32'h7FFF_FFFF;
    localparam int PMIN = 32'h8000_0000;

    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        pair_ch.valid <= 1'b0;
        pair_ch.data  <= '0;
        cycles        <= 0;
        burst_left    = 0;
        long_hold_req = 1'b0;
        cur_radius    = 64'd1048576;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on reset coefficients.
        send_pair(mk(ONE, 2 * ONE, ONE, -ONE, 10 * ONE, 20 * ONE, 31'd65536, 31'd65536, 0, 0));
        send_pair(mk(0, 0, 3 * ONE, ONE, 5 * ONE, 5 * ONE, 31'd131072, 31'd65536, 0, 1));
        send_pair(mk(ONE, ONE, ONE, ONE, ONE, ONE, 31'd0, 31'd65536, 0, 1));
        send_pair(mk(20 * ONE, 0, ONE, ONE, ONE, ONE, 31'd0, 31'd65536, 0, 1));
        send_pair(mk(ONE, 0, ONE, ONE, ONE, ONE, 31'd65536, 31'd65536, 1, 1));
        send_pair(mk(ONE, ONE, ONE, ONE, ONE, ONE, 31'd65536, 31'd0, 0, 1));
        send_pair(mk(ONE, -ONE, PMAX, PMIN, PMAX, PMAX, 31'd1, 31'd1, 0, 0));
        send_pair(mk(-ONE, ONE, PMIN, PMAX, PMIN, PMIN, 31'd1, 31'd1, 0, 1));
        send_pair(mk(PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 1));
        send_pair(mk(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 1));
        send_pair(mk(15 * ONE, 5 * ONE, ONE, 0, ONE, 0, 31'd65536, 31'd65536, 0, 1));
        send_pair(mk(0, -ONE / 2, 0, ONE, -ONE, ONE, 31'd3, 31'd5, 0, 1));
        drain();
        random_phase(200);
        drain();

        // Typical values, with a long receiver hold-off at the start.
        write_all(31'(2 * ONE), 31'(2 * ONE), 31'(3 * ONE), 48'hFFFF_FF00_0000,
                  48'h00_4000_0000, 32'(-10 * ONE));
        long_hold_req = 1'b1;
        random_phase(200);
        drain();

        // Upper extremes.
        write_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF,
                  48'h7FFF_FFFF_FFFF, 32'h7FFF_FFFF);
        random_phase(200);
        drain();

        // Lower extremes; a zero radius leaves only the gravity term.
        write_all(31'd0, 31'd0, 31'd0, 48'h8000_0000_0000, 48'h8000_0000_0000, 32'h8000_0000);
        random_phase(60);
        drain();
        write_all(31'(8 * ONE), 31'd1, 31'd1, 48'h8000_0000_0000, 48'h8000_0000_0000,
                  32'h8000_0000);
        random_phase(140);
        drain();

        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule
